@@ src/srs_pkg.sv @@
// Shared constants, types and helper functions of the selective-repeat sender.
package srs_pkg;

	localparam int MAX_WINDOW = 32;
	localparam int WIN_CAP    = (MAX_WINDOW < 32) ? MAX_WINDOW : 32;
	localparam int SLOT_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int WIN_W      = 7;

	localparam logic [1:0] FUNC_BEGIN = 2'd0;
	localparam logic [1:0] FUNC_RX    = 2'd1;
	localparam logic [1:0] FUNC_TICK  = 2'd2;

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_DATA  = 2'd2;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_START = 2'd1;
	localparam logic [1:0] PH_DATA  = 2'd2;
	localparam logic [1:0] PH_END   = 2'd3;

	localparam logic [1:0] CFG_WINDOW  = 2'd0;
	localparam logic [1:0] CFG_TOTAL   = 2'd1;
	localparam logic [1:0] CFG_SEQ     = 2'd2;
	localparam logic [1:0] CFG_TIMEOUT = 2'd3;

	localparam logic [31:0] ACK_TYPE = 32'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] seq;
		logic        done;
	} res_t;

	typedef logic [SLOT_W-1:0] slot_t;

	function automatic slot_t slot_inc(input slot_t a);
		slot_t r;
		if (a == slot_t'(MAX_WINDOW - 1)) begin
			r = '0;
		end else begin
			r = a + slot_t'(1);
		end
		return r;
	endfunction

	function automatic slot_t slot_add(input slot_t a, input logic [SLOT_W:0] off);
		logic [SLOT_W:0] sum;
		sum = {1'b0, a} + off;
		if (sum >= (SLOT_W+1)'(MAX_WINDOW)) begin
			sum = sum - (SLOT_W+1)'(MAX_WINDOW);
		end
		return sum[SLOT_W-1:0];
	endfunction

endpackage

@@ src/selective_repeat_sender_unit.sv @@
// Top level of the selective-repeat sender control with its sequencer and stamp memory.
// Begin, a handshake header, an ignored header, an unused function, and a tick outside the data
// phase or one that only ends it go from dispatch straight to the finishing state. An
// acknowledgement that completes the START handshake first issues the DATA orders of the first
// window. An acknowledgement in the data phase that marks a slot slides the base over the
// acknowledged slots at its front and then issues the DATA orders of the refill, or starts the
// END handshake once the base reaches the total. Any other tick in the data phase scans the
// outstanding packets, reading the send-stamp memory one slot per cycle. Results leave on
// strobe and cannot be stalled; last marks the final result of a command, and busy falls in
// the cycle in which that result is shown.
module selective_repeat_sender_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [31:0] rx_type,
	input  logic [31:0] rx_sequence,
	input  logic [31:0] rx_length,
	output logic        strobe,
	output logic [1:0]  send_kind,
	output logic [31:0] send_sequence,
	output logic        transfer_done,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DISP   = 3'd1;
	localparam logic [2:0] S_SLIDE  = 3'd2;
	localparam logic [2:0] S_REFILL = 3'd3;
	localparam logic [2:0] S_SCAN   = 3'd4;
	localparam logic [2:0] S_FIN    = 3'd5;

	logic [2:0]  state_q;
	logic [1:0]  phase_q;
	logic [5:0]  window_q;
	logic [31:0] total_q, start_seq_q;
	logic [15:0] timeout_q, timer_q;
	logic [31:0] wb_q, nu_q, tick_q, scan_q;
	srs_pkg::slot_t base_slot_q, nu_slot_q, scan_slot_q, slot_s1;
	logic        v_s1;
	logic [31:0] seq_s1;
	logic        end_chk_q;
	logic [srs_pkg::MAX_WINDOW-1:0] sent_q, acked_q;
	logic [1:0]  func_q;
	logic [31:0] type_q, rseq_q, len_q;
	srs_pkg::res_t pend_q, out_q, em;
	logic        pend_v_q, out_v_q, out_last_q, em_v;
	logic        ram_we;
	srs_pkg::slot_t ram_waddr;
	logic [31:0] ram_rdata;

	logic [srs_pkg::WIN_W-1:0] w_eff;
	logic [15:0] to_eff, timer_inc;
	logic        refill_go, slide_go, base_done, rx_match, ack_ok, ack_fresh, hit, timer_hit;
	logic [31:0] ack_off;
	srs_pkg::slot_t ack_slot;

	assign w_eff = (window_q == 6'd0) ? srs_pkg::WIN_W'(1) :
		((srs_pkg::WIN_W'(window_q) > srs_pkg::WIN_W'(srs_pkg::WIN_CAP)) ?
		srs_pkg::WIN_W'(srs_pkg::WIN_CAP) : srs_pkg::WIN_W'(window_q));
	assign to_eff    = (timeout_q == 16'd0) ? 16'd1 : timeout_q;
	assign timer_inc = timer_q + 16'd1;
	assign timer_hit = timer_inc >= to_eff;
	assign base_done = wb_q >= total_q;
	assign refill_go = (nu_q < total_q) && ((nu_q - wb_q) < {25'd0, w_eff});
	assign slide_go  = (wb_q < total_q) && (wb_q < nu_q) && acked_q[base_slot_q];
	assign rx_match  = (type_q == srs_pkg::ACK_TYPE) && (len_q == 32'd0) &&
		(rseq_q == start_seq_q);
	assign ack_off   = rseq_q - wb_q;
	assign ack_ok    = (type_q == srs_pkg::ACK_TYPE) && (len_q == 32'd0) &&
		(rseq_q < total_q) && (ack_off < (nu_q - wb_q));
	assign ack_slot  = srs_pkg::slot_add(base_slot_q, ack_off[srs_pkg::SLOT_W:0]);
	assign ack_fresh = sent_q[ack_slot] && !acked_q[ack_slot];
	assign hit       = v_s1 && sent_q[slot_s1] && !acked_q[slot_s1] &&
		((tick_q - ram_rdata) >= {16'd0, to_eff});

	assign busy      = state_q != S_IDLE;
	assign cfg_ready = 1'b1;
	assign strobe        = out_v_q;
	assign send_kind     = out_q.kind;
	assign send_sequence = out_q.seq;
	assign transfer_done = out_q.done;
	assign last          = out_last_q;

	always_comb begin
		em_v      = 1'b0;
		em        = '{kind: srs_pkg::KIND_START, seq: start_seq_q, done: 1'b0};
		ram_we    = 1'b0;
		ram_waddr = nu_slot_q;
		case (state_q)
			S_DISP: begin
				case (func_q)
					srs_pkg::FUNC_BEGIN: em_v = 1'b1;
					srs_pkg::FUNC_RX: begin
						if (phase_q == srs_pkg::PH_START) begin
							em_v = !rx_match;
						end else if (phase_q == srs_pkg::PH_END) begin
							em_v = 1'b1;
							if (rx_match) begin
								em = '{kind: srs_pkg::KIND_START, seq: 32'd0, done: 1'b1};
							end else begin
								em.kind = srs_pkg::KIND_END;
							end
						end
					end
					srs_pkg::FUNC_TICK: begin
						if (phase_q == srs_pkg::PH_START) begin
							em_v = timer_hit;
						end else if (phase_q == srs_pkg::PH_END) begin
							em_v    = timer_hit;
							em.kind = srs_pkg::KIND_END;
						end else if (phase_q == srs_pkg::PH_DATA) begin
							em_v    = base_done;
							em.kind = srs_pkg::KIND_END;
						end
					end
					default: em_v = 1'b0;
				endcase
			end
			S_SLIDE: begin
				em_v    = !slide_go && base_done;
				em.kind = srs_pkg::KIND_END;
			end
			S_REFILL: begin
				if (refill_go) begin
					em_v   = 1'b1;
					em     = '{kind: srs_pkg::KIND_DATA, seq: nu_q, done: 1'b0};
					ram_we = 1'b1;
				end else begin
					em_v    = end_chk_q && base_done;
					em.kind = srs_pkg::KIND_END;
				end
			end
			S_SCAN: begin
				if (hit) begin
					em_v      = 1'b1;
					em        = '{kind: srs_pkg::KIND_DATA, seq: seq_s1, done: 1'b0};
					ram_we    = 1'b1;
					ram_waddr = slot_s1;
				end
			end
			default: em_v = 1'b0;
		endcase
	end

	srs_ram #(
		.WIDTH(32),
		.DEPTH(srs_pkg::MAX_WINDOW)
	) u_stamp_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (tick_q),
		.raddr (scan_slot_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= srs_pkg::PH_IDLE;
			window_q    <= 6'd1;
			total_q     <= '0;
			start_seq_q <= '0;
			timeout_q   <= 16'd10;
			timer_q     <= '0;
			wb_q        <= '0;
			nu_q        <= '0;
			tick_q      <= '0;
			base_slot_q <= '0;
			nu_slot_q   <= '0;
			sent_q      <= '0;
			acked_q     <= '0;
			v_s1        <= 1'b0;
			end_chk_q   <= 1'b0;
			pend_v_q    <= 1'b0;
			out_v_q     <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			out_v_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					srs_pkg::CFG_WINDOW:  window_q    <= cfg_data[5:0];
					srs_pkg::CFG_TOTAL:   total_q     <= cfg_data;
					srs_pkg::CFG_SEQ:     start_seq_q <= cfg_data;
					srs_pkg::CFG_TIMEOUT: timeout_q   <= cfg_data[15:0];
					default:              timeout_q   <= timeout_q;
				endcase
			end
			if (em_v) begin
				pend_q   <= em;
				pend_v_q <= 1'b1;
				if (pend_v_q) begin
					out_q      <= pend_q;
					out_v_q    <= 1'b1;
					out_last_q <= 1'b0;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						func_q  <= func;
						type_q  <= rx_type;
						rseq_q  <= rx_sequence;
						len_q   <= rx_length;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					state_q <= S_FIN;
					case (func_q)
						srs_pkg::FUNC_BEGIN: begin
							sent_q      <= '0;
							acked_q     <= '0;
							wb_q        <= '0;
							nu_q        <= '0;
							base_slot_q <= '0;
							nu_slot_q   <= '0;
							timer_q     <= '0;
							phase_q     <= srs_pkg::PH_START;
						end
						srs_pkg::FUNC_RX: begin
							if (phase_q == srs_pkg::PH_START) begin
								if (rx_match) begin
									phase_q   <= srs_pkg::PH_DATA;
									end_chk_q <= 1'b1;
									state_q   <= S_REFILL;
								end else begin
									timer_q <= '0;
								end
							end else if (phase_q == srs_pkg::PH_END) begin
								if (rx_match) begin
									phase_q <= srs_pkg::PH_IDLE;
								end else begin
									timer_q <= '0;
								end
							end else if (phase_q == srs_pkg::PH_DATA) begin
								if (ack_ok && ack_fresh) begin
									acked_q[ack_slot] <= 1'b1;
									state_q           <= S_SLIDE;
								end
							end
						end
						srs_pkg::FUNC_TICK: begin
							tick_q <= tick_q + 32'd1;
							if (phase_q == srs_pkg::PH_START || phase_q == srs_pkg::PH_END) begin
								timer_q <= timer_hit ? 16'd0 : timer_inc;
							end else if (phase_q == srs_pkg::PH_DATA) begin
								if (base_done) begin
									phase_q <= srs_pkg::PH_END;
									timer_q <= '0;
								end else begin
									scan_q      <= wb_q;
									scan_slot_q <= base_slot_q;
									v_s1        <= 1'b0;
									state_q     <= S_SCAN;
								end
							end
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_SLIDE: begin
					if (slide_go) begin
						sent_q[base_slot_q]  <= 1'b0;
						acked_q[base_slot_q] <= 1'b0;
						wb_q                 <= wb_q + 32'd1;
						base_slot_q          <= srs_pkg::slot_inc(base_slot_q);
					end else if (base_done) begin
						phase_q <= srs_pkg::PH_END;
						timer_q <= '0;
						state_q <= S_FIN;
					end else begin
						end_chk_q <= 1'b0;
						state_q   <= S_REFILL;
					end
				end
				S_REFILL: begin
					if (refill_go) begin
						sent_q[nu_slot_q]  <= 1'b1;
						acked_q[nu_slot_q] <= 1'b0;
						nu_q               <= nu_q + 32'd1;
						nu_slot_q          <= srs_pkg::slot_inc(nu_slot_q);
					end else begin
						if (end_chk_q && base_done) begin
							phase_q <= srs_pkg::PH_END;
							timer_q <= '0;
						end
						state_q <= S_FIN;
					end
				end
				S_SCAN: begin
					if (scan_q != nu_q) begin
						v_s1        <= 1'b1;
						seq_s1      <= scan_q;
						slot_s1     <= scan_slot_q;
						scan_q      <= scan_q + 32'd1;
						scan_slot_q <= srs_pkg::slot_inc(scan_slot_q);
					end else begin
						v_s1 <= 1'b0;
						if (!v_s1) begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (pend_v_q) begin
						out_q      <= pend_q;
						out_v_q    <= 1'b1;
						out_last_q <= 1'b1;
						pend_v_q   <= 1'b0;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && transfer_done |-> last)
		else $error("completion result not marked last");

	a_strobe_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result shown without a command in progress");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy)
		else $error("final result shown while command still in progress");

	a_no_pending_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_v_q)
		else $error("result left pending after command finished");

	a_window_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(nu_q - wb_q) <= 32'(srs_pkg::MAX_WINDOW))
		else $error("outstanding packets exceed the slot ring");
endmodule

@@ src/srs_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module srs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ bench/selective_repeat_sender_unit_tb.sv @@
// Self-checking testbench of the selective-repeat sender control with a send-order predictor.
`timescale 1ns / 1ps

module selective_repeat_sender_unit_tb;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int NSLOT = srs_pkg::MAX_WINDOW;

	class send_order_board;
		bit [5:0]  window_size;
		bit [31:0] total_packets;
		bit [31:0] start_seq;
		bit [15:0] timeout_ticks;
		bit [1:0]  phase;
		bit [31:0] base_seq;
		bit [31:0] next_seq;
		bit [31:0] ticks;
		bit [15:0] hs_timer;
		bit        sent_flag [NSLOT];
		bit        acked_flag [NSLOT];
		bit [31:0] stamp [NSLOT];
		srs_pkg::res_t pending [$];
		bit        last_flags [$];
		int        last_base;
		int        mismatches;
		int        orders_checked;
		int        rx_count;
		int        tick_count_in;

		function new();
			window_size = 1;
			total_packets = 0;
			start_seq = 0;
			timeout_ticks = 10;
			phase = srs_pkg::PH_IDLE;
			base_seq = 0;
			next_seq = 0;
			ticks = 0;
			hs_timer = 0;
			last_base = 0;
			mismatches = 0;
			orders_checked = 0;
			rx_count = 0;
			tick_count_in = 0;
			foreach (sent_flag[i]) begin
				sent_flag[i] = 0;
				acked_flag[i] = 0;
				stamp[i] = 0;
			end
		endfunction

		function void write_reg(bit [1:0] idx, bit [31:0] data);
			case (idx)
				srs_pkg::CFG_WINDOW: window_size = data[5:0];
				srs_pkg::CFG_TOTAL: total_packets = data;
				srs_pkg::CFG_SEQ: start_seq = data;
				srs_pkg::CFG_TIMEOUT: timeout_ticks = data[15:0];
				default: ;
			endcase
		endfunction

		function bit [31:0] eff_window();
			bit [31:0] w;
			w = window_size;
			if (w == 0) w = 1;
			if (w > srs_pkg::WIN_CAP) w = srs_pkg::WIN_CAP;
			return w;
		endfunction

		function bit [31:0] eff_timeout();
			return (timeout_ticks == 0) ? 32'd1 : {16'd0, timeout_ticks};
		endfunction

		function void push(bit [1:0] kind, bit [31:0] seq, bit done);
			srs_pkg::res_t r;
			if (pending.size() >= 32 + last_base) return;
			r.kind = kind;
			r.seq = seq;
			r.done = done;
			pending.push_back(r);
			last_flags.push_back(1'b0);
		endfunction

		function void send_data(bit [31:0] seq);
			sent_flag[seq % NSLOT] = 1;
			stamp[seq % NSLOT] = ticks;
			push(srs_pkg::KIND_DATA, seq, 0);
		endfunction

		function void enter_end();
			phase = srs_pkg::PH_END;
			hs_timer = 0;
			push(srs_pkg::KIND_END, start_seq, 0);
		endfunction

		function void refill();
			while (next_seq < total_packets && next_seq - base_seq < eff_window()) begin
				acked_flag[next_seq % NSLOT] = 0;
				send_data(next_seq);
				next_seq++;
			end
		endfunction

		function bit hs_match(bit [31:0] t, bit [31:0] s, bit [31:0] l);
			return t == srs_pkg::ACK_TYPE && l == 0 && s == start_seq;
		endfunction

		function void note_command(bit [1:0] fn, bit [31:0] t, bit [31:0] s, bit [31:0] l);
			bit [31:0] q;
			last_base = pending.size();
			if (fn == srs_pkg::FUNC_RX) rx_count++;
			if (fn == srs_pkg::FUNC_TICK) tick_count_in++;
			if (fn == srs_pkg::FUNC_BEGIN) begin
				foreach (sent_flag[i]) begin
					sent_flag[i] = 0;
					acked_flag[i] = 0;
				end
				base_seq = 0;
				next_seq = 0;
				hs_timer = 0;
				phase = srs_pkg::PH_START;
				push(srs_pkg::KIND_START, start_seq, 0);
			end else if (fn == srs_pkg::FUNC_RX) begin
				if (phase == srs_pkg::PH_START) begin
					if (hs_match(t, s, l)) begin
						phase = srs_pkg::PH_DATA;
						refill();
						if (base_seq >= total_packets) enter_end();
					end else begin
						hs_timer = 0;
						push(srs_pkg::KIND_START, start_seq, 0);
					end
				end else if (phase == srs_pkg::PH_END) begin
					if (hs_match(t, s, l)) begin
						phase = srs_pkg::PH_IDLE;
						push(srs_pkg::KIND_START, 0, 1);
					end else begin
						hs_timer = 0;
						push(srs_pkg::KIND_END, start_seq, 0);
					end
				end else if (phase == srs_pkg::PH_DATA) begin
					if (t == srs_pkg::ACK_TYPE && l == 0 && s < total_packets &&
							s - base_seq < next_seq - base_seq &&
							sent_flag[s % NSLOT] && !acked_flag[s % NSLOT]) begin
						acked_flag[s % NSLOT] = 1;
						while (base_seq < total_packets && base_seq < next_seq &&
								acked_flag[base_seq % NSLOT]) begin
							sent_flag[base_seq % NSLOT] = 0;
							acked_flag[base_seq % NSLOT] = 0;
							base_seq++;
						end
						if (base_seq >= total_packets) enter_end();
						else refill();
					end
				end
			end else if (fn == srs_pkg::FUNC_TICK) begin
				ticks++;
				if (phase == srs_pkg::PH_START || phase == srs_pkg::PH_END) begin
					hs_timer++;
					if (hs_timer >= eff_timeout()) begin
						hs_timer = 0;
						push(phase == srs_pkg::PH_START ? srs_pkg::KIND_START : srs_pkg::KIND_END,
							start_seq, 0);
					end
				end else if (phase == srs_pkg::PH_DATA) begin
					if (base_seq >= total_packets) enter_end();
					else begin
						for (q = base_seq; q != next_seq; q++) begin
							if (sent_flag[q % NSLOT] && !acked_flag[q % NSLOT] &&
									ticks - stamp[q % NSLOT] >= eff_timeout())
								send_data(q);
						end
					end
				end
			end
			if (pending.size() > last_base) last_flags[last_flags.size() - 1] = 1'b1;
		endfunction

		function void check_order(bit [1:0] kind, bit [31:0] seq, bit done, bit lst);
			srs_pkg::res_t e;
			bit el;
			orders_checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected send order kind=%0d seq=%0h done=%0b last=%0b",
						kind, seq, done, lst);
				return;
			end
			e = pending.pop_front();
			el = last_flags.pop_front();
			if (e.kind != kind || e.seq != seq || e.done != done || el != lst) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"order mismatch: expected kind=%0d seq=%0h done=%0b last=%0b,",
						" got kind=%0d seq=%0h done=%0b last=%0b"},
						e.kind, e.seq, e.done, el, kind, seq, done, lst);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	logic [1:0]  func = 0;
	logic [31:0] rx_type = 0;
	logic [31:0] rx_sequence = 0;
	logic [31:0] rx_length = 0;
	logic        strobe;
	logic [1:0]  send_kind;
	logic [31:0] send_sequence;
	logic        transfer_done;
	logic        last;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 0;
	logic [31:0] cfg_data = 0;

	send_order_board board = new();
	int cycles = 0;
	int sent_items = 0;
	int transfers_begun = 0;

	always #4 clk = ~clk;

	selective_repeat_sender_unit dut (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (strobe) board.check_order(send_kind, send_sequence, transfer_done, last);
		if (cycles > 3000000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
		repeat (n) @(posedge clk);
	endtask

	task automatic issue(bit [1:0] fn, bit [31:0] t, bit [31:0] s, bit [31:0] l);
		start <= 1;
		func <= fn;
		rx_type <= t;
		rx_sequence <= s;
		rx_length <= l;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (fn != FUNC_UNUSED) board.note_command(fn, t, s, l);
		if (fn == srs_pkg::FUNC_BEGIN) transfers_begun++;
		sent_items++;
		if ($urandom_range(0, 3) != 0) begin
			start <= 0;
			idle_gap();
		end
	endtask

	task automatic quiesce();
		start <= 0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(bit [1:0] idx, bit [31:0] data);
		start <= 0;
		@(posedge clk);
		while (busy) @(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.write_reg(idx, data);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic ack_of(bit [31:0] s);
		issue(srs_pkg::FUNC_RX, srs_pkg::ACK_TYPE, s, 0);
	endtask

	task automatic run_transfer(int n_items);
		int k;
		bit [31:0] s;
		issue(srs_pkg::FUNC_BEGIN, $urandom, $urandom, $urandom);
		if ($urandom_range(0, 3) == 0) issue(srs_pkg::FUNC_TICK, 0, 0, 0);
		ack_of(board.start_seq);
		for (k = 0; k < n_items; k++) begin
			case ($urandom_range(0, 9))
				0, 1: issue(srs_pkg::FUNC_TICK, $urandom, $urandom, $urandom);
				2: issue(srs_pkg::FUNC_RX, $urandom, $urandom, $urandom);
				3: issue($urandom_range(0, 1) ? FUNC_UNUSED : srs_pkg::FUNC_RX,
					srs_pkg::ACK_TYPE, 32'(board.base_seq + $urandom_range(0, 40)),
					$urandom_range(0, 1));
				default: begin
					if (board.phase == srs_pkg::PH_END) s = board.start_seq;
					else if (board.next_seq != board.base_seq)
						s = board.base_seq +
							$urandom_range(0, board.next_seq - board.base_seq - 1);
					else s = board.base_seq;
					ack_of(s);
				end
			endcase
			if (board.phase == srs_pkg::PH_IDLE) break;
		end
		if (board.phase == srs_pkg::PH_END) ack_of(board.start_seq);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// Directed: idle traffic, bare extremes, handshake retries, empty transfer.
		issue(srs_pkg::FUNC_TICK, 0, 0, 0);
		issue(srs_pkg::FUNC_RX, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		issue(FUNC_UNUSED, 0, 0, 0);
		write_reg(srs_pkg::CFG_TIMEOUT, 0);
		write_reg(srs_pkg::CFG_SEQ, 32'hFFFFFFFF);
		issue(srs_pkg::FUNC_BEGIN, 0, 0, 0);
		issue(srs_pkg::FUNC_TICK, 0, 0, 0);
		issue(srs_pkg::FUNC_RX, srs_pkg::ACK_TYPE, 32'hFFFFFFFF, 1);
		issue(srs_pkg::FUNC_BEGIN, 0, 0, 0);
		ack_of(32'hFFFFFFFF);
		issue(srs_pkg::FUNC_RX, 0, 32'hFFFFFFFF, 0);
		issue(srs_pkg::FUNC_TICK, 0, 0, 0);
		ack_of(32'hFFFFFFFF);
		quiesce();
		write_reg(srs_pkg::CFG_WINDOW, 0);
		write_reg(srs_pkg::CFG_TOTAL, 3);
		write_reg(srs_pkg::CFG_TIMEOUT, 2);
		write_reg(srs_pkg::CFG_SEQ, 0);
		run_transfer(15);
		quiesce();

		// Extreme window with a long transfer, then a shrunken total mid-transfer.
		write_reg(srs_pkg::CFG_WINDOW, 63);
		write_reg(srs_pkg::CFG_TOTAL, 40);
		write_reg(srs_pkg::CFG_TIMEOUT, 3);
		run_transfer(60);
		quiesce();
		write_reg(srs_pkg::CFG_WINDOW, 32);
		write_reg(srs_pkg::CFG_TOTAL, 32'hFFFFFFFF);
		write_reg(srs_pkg::CFG_TIMEOUT, 16'hFFFF);
		issue(srs_pkg::FUNC_BEGIN, 0, 0, 0);
		ack_of(0);
		repeat (5) ack_of(board.base_seq);
		quiesce();
		write_reg(srs_pkg::CFG_TOTAL, 0);
		issue(srs_pkg::FUNC_TICK, 0, 0, 0);
		ack_of(0);
		quiesce();

		while (sent_items < 290) begin
			write_reg(srs_pkg::CFG_WINDOW, $urandom_range(0, 63));
			write_reg(srs_pkg::CFG_TOTAL, $urandom_range(0, 20));
			write_reg(srs_pkg::CFG_SEQ, $urandom);
			write_reg(srs_pkg::CFG_TIMEOUT, $urandom_range(0, 6));
			run_transfer($urandom_range(10, 50));
			quiesce();
		end

		$display("Ran %0d commands over %0d transfers (%0d headers, %0d ticks).",
			sent_items, transfers_begun, board.rx_count, board.tick_count_in);
		$display("Checked %0d send orders.", board.orders_checked);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
